// ----- rtl/cda_pkg.sv -----
// Shared types, constants and calendar functions for the date adder.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package cda_pkg;

    localparam int MAX_YEAR_DEF  = 9999;
    localparam int ADD_WIDTH_DEF = 16;

    localparam int OP_W     = 2;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int ADD_IN_W = 16;
    localparam int DOY_W    = 9;
    localparam int STATUS_W = 2;
    localparam int R400_W   = 9;

    localparam int MONTHS     = 12;
    localparam int CYCLE_400  = 400;
    localparam int COMMON_LEN = 365;
    localparam int LEAP_LEN   = 366;
    localparam int FEB_LIMIT  = 29;
    localparam int DEC_LAST   = 31;

    // Year / 400 as a multiply by a scaled reciprocal; exact for any 14-bit year.
    localparam int DIV400_MUL   = 20972;
    localparam int DIV400_MUL_W = 15;
    localparam int DIV400_SHIFT = 23;
    localparam int Q400_W       = 6;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_QUERY = 2'd0;
    localparam op_t OP_SET   = 2'd1;
    localparam op_t OP_ADD   = 2'd2;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_REJECT   = 2'd1;
    localparam status_t STATUS_SATURATE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MOD,
        S_YEAR,
        S_MONTH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic load_set;
        logic load_add;
        logic div_step;
        logic mod_step;
        logic year_step;
        logic saturate;
        logic month_init;
        logic month_step;
        logic month_done;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic year_more;
        logic year_at_max;
        logic month_more;
    } stat_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // Leap test from the year modulo 400: divisible by 4 and not a plain century.
    function automatic logic is_leap(input logic [R400_W-1:0] r);
        return (r[1:0] == 2'd0) && (r != R400_W'(100)) && (r != R400_W'(200))
            && (r != R400_W'(300));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        n = month_days(m);
        if (m == MONTH_W'(2) && leap)
            n = DAY_W'(FEB_LIMIT);
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cda_if.sv -----
// Valid/ready channel interfaces for the request and response words.
// Depends on cda_pkg for the field widths.
`default_nettype none

interface cda_req_if;
    logic                         valid;
    logic                         ready;
    logic [cda_pkg::OP_W-1:0]     operation;
    logic [cda_pkg::MONTH_W-1:0]  month_in;
    logic [cda_pkg::DAY_W-1:0]    day_in;
    logic [cda_pkg::YEAR_W-1:0]   year_in;
    logic [cda_pkg::ADD_IN_W-1:0] days_to_add;

    modport source (output valid, operation, month_in, day_in, year_in, days_to_add,
                    input ready);
    modport sink   (input valid, operation, month_in, day_in, year_in, days_to_add,
                    output ready);
endinterface

interface cda_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cda_pkg::MONTH_W-1:0]  month_out;
    logic [cda_pkg::DAY_W-1:0]    day_out;
    logic [cda_pkg::YEAR_W-1:0]   year_out;
    logic [cda_pkg::DOY_W-1:0]    day_of_year;
    logic [cda_pkg::DOY_W-1:0]    days_left;
    logic [cda_pkg::DAY_W-1:0]    month_length;
    logic                         leap_flag;
    logic [cda_pkg::STATUS_W-1:0] status;

    modport source (output valid, month_out, day_out, year_out, day_of_year, days_left,
                    month_length, leap_flag, status, input ready);
    modport sink   (input valid, month_out, day_out, year_out, day_of_year, days_left,
                    month_length, leap_flag, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/calendar_date_add_days.sv -----
// Top level of the Gregorian date adder: controller plus datapath.
// Depends on cda_pkg, cda_if, cda_ctrl and cda_datapath.
//
//   Channel  Direction  Handshake     Word
//   req      in         valid/ready   operation, month_in, day_in, year_in, days_to_add
//   rsp      out        valid/ready   date, day_of_year, days_left, month_length,
//                                     leap_flag, status
//
// A query goes from accept through S_FINISH into the response register; a set
// passes S_DIV and S_MOD first. An add runs S_YEAR and then S_MONTH, in which
// the day counter subtracts one year or one month length per cycle.
// A saturated add leaves S_YEAR for S_FINISH and skips S_MONTH.
// Reset gives 1 January of year 1. A new word is accepted while the previous
// response still waits in the output register; a stalled response holds the
// controller in its final state until the register is free.
`default_nettype none

module calendar_date_add_days #(
    parameter int MAX_YEAR  = cda_pkg::MAX_YEAR_DEF,
    parameter int ADD_WIDTH = cda_pkg::ADD_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cda_req_if.sink    req,
    cda_rsp_if.source  rsp
);

    cda_pkg::cmd_t  cmd;
    cda_pkg::stat_t stat;
    logic           in_ready;
    logic           out_valid;

    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .operation (cda_pkg::op_t'(req.operation)),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cda_datapath #(
        .MAX_YEAR  (MAX_YEAR),
        .ADD_WIDTH (ADD_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .month_in     (req.month_in),
        .day_in       (req.day_in),
        .year_in      (req.year_in),
        .days_to_add  (req.days_to_add),
        .month_out    (rsp.month_out),
        .day_out      (rsp.day_out),
        .year_out     (rsp.year_out),
        .day_of_year  (rsp.day_of_year),
        .days_left    (rsp.days_left),
        .month_length (rsp.month_length),
        .leap_flag    (rsp.leap_flag),
        .status       (rsp.status)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ----- rtl/cda_ctrl.sv -----
// Controller state machine of the date adder: sequences set, add and
// response steps. Depends on cda_pkg for states, commands and status.
`default_nettype none

module cda_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire cda_pkg::op_t    operation,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire cda_pkg::stat_t  stat,
    output cda_pkg::cmd_t        cmd
);

    cda_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cda_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cda_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == cda_pkg::OP_SET)
                        state_next = cda_pkg::S_DIV;
                    else if (operation == cda_pkg::OP_ADD)
                        state_next = cda_pkg::S_YEAR;
                    else
                        state_next = cda_pkg::S_FINISH;
                end
            end
            cda_pkg::S_DIV:
                state_next = cda_pkg::S_MOD;
            cda_pkg::S_MOD:
                state_next = cda_pkg::S_FINISH;
            cda_pkg::S_YEAR:
            begin
                if (stat.year_more && stat.year_at_max)
                    state_next = cda_pkg::S_FINISH;
                else if (!stat.year_more)
                    state_next = cda_pkg::S_MONTH;
            end
            cda_pkg::S_MONTH:
            begin
                if (!stat.month_more)
                    state_next = cda_pkg::S_FINISH;
            end
            cda_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = cda_pkg::S_IDLE;
            end
            default:
                state_next = cda_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            cda_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.start    = in_valid;
                cmd.load_set = in_valid && (operation == cda_pkg::OP_SET);
                cmd.load_add = in_valid && (operation == cda_pkg::OP_ADD);
            end
            cda_pkg::S_DIV:
                cmd.div_step = 1'b1;
            cda_pkg::S_MOD:
                cmd.mod_step = 1'b1;
            cda_pkg::S_YEAR:
            begin
                cmd.saturate   = stat.year_more && stat.year_at_max;
                cmd.year_step  = stat.year_more && !stat.year_at_max;
                cmd.month_init = !stat.year_more;
            end
            cda_pkg::S_MONTH:
            begin
                cmd.month_step = stat.month_more;
                cmd.month_done = !stat.month_more;
            end
            cda_pkg::S_FINISH:
                cmd.out_load = !out_valid_reg || out_ready;
            default:
                cmd = '0;
        endcase
    end

    // The response register keeps its word until the sink takes it.
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/cda_datapath.sv -----
// Datapath of the date adder: stored date, year-mod-400 tracking, day
// counter for year and month stepping, and the response register.
// Depends on cda_pkg for widths, tables and the command/status structs.
`default_nettype none

module cda_datapath #(
    parameter int MAX_YEAR  = cda_pkg::MAX_YEAR_DEF,
    parameter int ADD_WIDTH = cda_pkg::ADD_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cda_pkg::cmd_t                cmd,
    output cda_pkg::stat_t                    stat,
    input  wire logic [cda_pkg::MONTH_W-1:0]  month_in,
    input  wire logic [cda_pkg::DAY_W-1:0]    day_in,
    input  wire logic [cda_pkg::YEAR_W-1:0]   year_in,
    input  wire logic [cda_pkg::ADD_IN_W-1:0] days_to_add,
    output logic [cda_pkg::MONTH_W-1:0]       month_out,
    output logic [cda_pkg::DAY_W-1:0]         day_out,
    output logic [cda_pkg::YEAR_W-1:0]        year_out,
    output logic [cda_pkg::DOY_W-1:0]         day_of_year,
    output logic [cda_pkg::DOY_W-1:0]         days_left,
    output logic [cda_pkg::DAY_W-1:0]         month_length,
    output logic                              leap_flag,
    output logic [cda_pkg::STATUS_W-1:0]      status
);

    localparam int MW  = cda_pkg::MONTH_W;
    localparam int DW  = cda_pkg::DAY_W;
    localparam int YW  = cda_pkg::YEAR_W;
    localparam int RW  = cda_pkg::R400_W;
    localparam int QW  = cda_pkg::Q400_W;
    localparam int LW  = cda_pkg::DOY_W;
    localparam int PW  = YW + cda_pkg::DIV400_MUL_W;
    localparam int ADD_USE = (ADD_WIDTH < cda_pkg::ADD_IN_W) ? ADD_WIDTH : cda_pkg::ADD_IN_W;
    localparam int NW  = ADD_USE + 2;

    logic [MW-1:0]             month_reg, month_next;
    logic [DW-1:0]             day_reg, day_next;
    logic [YW-1:0]             year_reg, year_next;
    logic [RW-1:0]             r400_reg, r400_next;
    cda_pkg::status_t          status_reg, status_next;
    logic [QW-1:0]             q_reg, q_next;
    logic [NW-1:0]             n_reg, n_next;

    logic [MW-1:0]             out_month_reg;
    logic [DW-1:0]             out_day_reg;
    logic [YW-1:0]             out_year_reg;
    logic [LW-1:0]             out_doy_reg;
    logic [LW-1:0]             out_left_reg;
    logic [DW-1:0]             out_mlen_reg;
    logic                      out_leap_reg;
    cda_pkg::status_t          out_status_reg;

    logic                      leap;
    logic [LW-1:0]             ylen;
    logic [DW-1:0]             mlen;
    logic [LW-1:0]             doy;
    logic [LW-1:0]             left;
    logic [DW-1:0]             set_limit;
    logic                      month_ok, day_ok, year_ok;
    logic [PW-1:0]             prod;
    logic [YW-1:0]             q_times;
    logic [YW-1:0]             r_full;

    always_comb
    begin
        leap = cda_pkg::is_leap(r400_reg);
        ylen = leap ? LW'(cda_pkg::LEAP_LEN) : LW'(cda_pkg::COMMON_LEN);
        mlen = cda_pkg::month_len(month_reg, leap);
        doy  = cda_pkg::days_before(month_reg) + LW'(day_reg)
             + LW'((month_reg > MW'(2)) && leap);
        left = (ylen >= doy) ? ylen - doy : '0;

        // A set checks the day against the requested month, February at 29.
        set_limit = (month_in == MW'(2)) ? DW'(cda_pkg::FEB_LIMIT)
                                         : cda_pkg::month_days(month_in);
        month_ok  = (month_in >= MW'(1)) && (month_in <= MW'(cda_pkg::MONTHS));
        day_ok    = (day_in >= DW'(1)) && (day_in <= set_limit);
        year_ok   = (year_in >= YW'(1)) && (year_in <= YW'(MAX_YEAR));

        prod    = PW'(year_reg) * PW'(cda_pkg::DIV400_MUL);
        q_times = YW'(q_reg) * YW'(cda_pkg::CYCLE_400);
        r_full  = year_reg - q_times;

        stat.year_more   = n_reg > NW'(ylen);
        stat.year_at_max = year_reg >= YW'(MAX_YEAR);
        stat.month_more  = (month_reg < MW'(cda_pkg::MONTHS)) && (n_reg > NW'(mlen));
    end

    always_comb
    begin
        month_next  = month_reg;
        day_next    = day_reg;
        year_next   = year_reg;
        r400_next   = r400_reg;
        status_next = status_reg;
        q_next      = q_reg;
        n_next      = n_reg;

        if (cmd.start)
            status_next = cda_pkg::STATUS_OK;
        if (cmd.load_set)
        begin
            if (month_ok)
                month_next = month_in;
            if (day_ok)
                day_next = day_in;
            if (year_ok)
                year_next = year_in;
            if (!(month_ok && day_ok && year_ok))
                status_next = cda_pkg::STATUS_REJECT;
        end
        if (cmd.load_add)
            n_next = NW'(doy) + NW'(days_to_add[ADD_USE-1:0]);
        if (cmd.div_step)
            q_next = prod[cda_pkg::DIV400_SHIFT +: QW];
        if (cmd.mod_step)
            r400_next = r_full[RW-1:0];
        if (cmd.year_step)
        begin
            n_next    = n_reg - NW'(ylen);
            year_next = year_reg + YW'(1);
            r400_next = (r400_reg == RW'(cda_pkg::CYCLE_400 - 1)) ? '0 : r400_reg + RW'(1);
        end
        if (cmd.saturate)
        begin
            month_next  = MW'(cda_pkg::MONTHS);
            day_next    = DW'(cda_pkg::DEC_LAST);
            status_next = cda_pkg::STATUS_SATURATE;
        end
        if (cmd.month_init)
            month_next = MW'(1);
        if (cmd.month_step)
        begin
            n_next     = n_reg - NW'(mlen);
            month_next = month_reg + MW'(1);
        end
        if (cmd.month_done)
            day_next = n_reg[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            month_reg  <= MW'(1);
            day_reg    <= DW'(1);
            year_reg   <= YW'(1);
            r400_reg   <= RW'(1);
            status_reg <= cda_pkg::STATUS_OK;
        end
        else
        begin
            month_reg  <= month_next;
            day_reg    <= day_next;
            year_reg   <= year_next;
            r400_reg   <= r400_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        n_reg <= n_next;
        if (cmd.out_load)
        begin
            out_month_reg  <= month_reg;
            out_day_reg    <= day_reg;
            out_year_reg   <= year_reg;
            out_doy_reg    <= doy;
            out_left_reg   <= left;
            out_mlen_reg   <= mlen;
            out_leap_reg   <= leap;
            out_status_reg <= status_reg;
        end
    end

    assign month_out    = out_month_reg;
    assign day_out      = out_day_reg;
    assign year_out     = out_year_reg;
    assign day_of_year  = out_doy_reg;
    assign days_left    = out_left_reg;
    assign month_length = out_mlen_reg;
    assign leap_flag    = out_leap_reg;
    assign status       = out_status_reg;

endmodule

`default_nettype wire

// ----- rtl/cda_checker.sv -----
// Port-level checks for the date adder, bound to the top level.
// Depends on cda_pkg and cda_if.
`default_nettype none

module cda_checker (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cda_req_if.sink    req,
    cda_rsp_if.source  rsp
);

    // A stalled response word holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.year_out)
            && $stable(rsp.day_of_year) && $stable(rsp.status))
        else $error("response word changed while stalled");

    // Ordinal day and days remaining always add up to the year length.
    a_year_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (10'(rsp.day_of_year) + 10'(rsp.days_left)
            == (rsp.leap_flag ? 10'(cda_pkg::LEAP_LEN) : 10'(cda_pkg::COMMON_LEN))))
        else $error("day_of_year and days_left disagree with the year length");

    // A saturated add always reports 31 December.
    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == cda_pkg::STATUS_SATURATE)
            |-> (rsp.month_out == 4'd12) && (rsp.day_out == 5'd31))
        else $error("saturated result is not 31 December");

    // A 29-day month is only February of a leap year.
    a_feb_leap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.month_length == 5'd29) |-> rsp.leap_flag && (rsp.month_out == 4'd2))
        else $error("29-day month outside leap February");

    // The block never takes a request while the previous one is still in work.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted in back-to-back cycles");

endmodule

bind calendar_date_add_days cda_checker u_cda_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

`default_nettype wire
